/* hw/rtl/i2ssf_pkg.sv */
// Shared constants, types and segment table for the seven-segment frame core.
`default_nettype none

package i2ssf_pkg;

    localparam int DIGIT_COUNT = 4;

    // Clamp limits of the display
    localparam int TOP_VAL = 10 ** DIGIT_COUNT - 1;
    localparam int BOT_MAG = 10 ** (DIGIT_COUNT - 1) - 1;

    // Largest magnitude that can reach the digit serializer (input is 16 bits)
    localparam int MAG_MAX = (TOP_VAL < 32767) ? TOP_VAL : 32768;
    localparam int MAG_W   = $clog2(MAG_MAX + 1);
    localparam int IDX_W   = $clog2(DIGIT_COUNT + 1);

    // Divide by ten: x * 52429 >> 19 is exact for x below 81920
    localparam int DIV_RECIP = 52429;
    localparam int DIV_SHIFT = 19;
    localparam int PROD_W    = MAG_W + 16;

    localparam logic [7:0] SEG_MINUS = 8'h01;
    localparam logic [7:0] SEG_BLANK = 8'h00;
    localparam logic [7:0] START_BIT = 8'h80;
    localparam logic [7:0] AN1_BIT   = 8'h40;
    localparam logic [7:0] AN2_BIT   = 8'h20;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } item_t;

    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        unique case (digit)
            4'd0:    code = 8'h7E;
            4'd1:    code = 8'h30;
            4'd2:    code = 8'h6D;
            4'd3:    code = 8'h79;
            4'd4:    code = 8'h33;
            4'd5:    code = 8'h5B;
            4'd6:    code = 8'h5F;
            4'd7:    code = 8'h70;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h73;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/i2ssf_clamp.sv */
// Input register and saturation of the value to the displayable range.
`default_nettype none

module i2ssf_clamp
    import i2ssf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] shown_value,
    output logic                    item_valid,
    output item_t                   item,
    input  wire logic               item_take
);

    logic               val_reg;
    logic               val_next;
    logic signed [15:0] value_reg;
    logic signed [31:0] v_ext;
    logic signed [31:0] v_cl;
    logic signed [31:0] v_abs;
    logic               accept;

    assign in_stall = val_reg && !item_take;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        val_next = val_reg;
        if (accept)
        begin
            val_next = 1'b1;
        end
        else if (item_take)
        begin
            val_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= 1'b0;
        end
        else
        begin
            val_reg <= val_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg <= shown_value;
        end
    end

    // Saturate to top and bottom, then split into sign and magnitude
    always_comb
    begin
        v_ext = 32'(value_reg);
        v_cl  = v_ext;
        if (v_ext > 32'(TOP_VAL))
        begin
            v_cl = 32'(TOP_VAL);
        end
        else if (v_ext < -32'(BOT_MAG))
        begin
            v_cl = -32'(BOT_MAG);
        end
        v_abs    = v_cl[31] ? -v_cl : v_cl;
        item.neg = v_cl[31];
        item.mag = v_abs[MAG_W-1:0];
    end

    assign item_valid = val_reg;

endmodule

`default_nettype wire

/* hw/rtl/i2ssf_digit_ser.sv */
// Digit serializer: one frame byte per cycle into the output register while the output is not stalled.
`default_nettype none

module i2ssf_digit_ser
    import i2ssf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    input  wire item_t      item,
    output logic            item_take,
    input  wire logic       ann_one,
    input  wire logic       ann_two,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      frame_byte,
    output logic            frame_last
);

    logic             busy_reg;
    logic             busy_next;
    logic [MAG_W-1:0] mag_reg;
    logic [MAG_W-1:0] mag_next;
    logic             neg_reg;
    logic             minus_done_reg;
    logic             minus_done_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       byte_reg;
    logic [7:0]       byte_next;
    logic             last_reg;
    logic             last_next;

    logic              out_free;
    logic              emit;
    logic              at_last;
    logic [PROD_W-1:0] prod;
    logic [MAG_W-1:0]  quot;
    logic [MAG_W-1:0]  quot_x10;
    logic [MAG_W-1:0]  rem_full;
    logic [7:0]        code;

    assign out_free  = !out_valid_reg || !out_stall;
    assign emit      = busy_reg && out_free;
    assign at_last   = (idx_reg == IDX_W'(DIGIT_COUNT));
    assign item_take = item_valid && (!busy_reg || (emit && at_last));

    // Peel off the lowest decimal digit
    always_comb
    begin
        prod     = PROD_W'(mag_reg) * PROD_W'(DIV_RECIP);
        quot     = MAG_W'(prod >> DIV_SHIFT);
        quot_x10 = MAG_W'({quot, 3'b000}) + MAG_W'({quot, 1'b0});
        rem_full = mag_reg - quot_x10;
    end

    always_comb
    begin
        mag_next        = mag_reg;
        minus_done_next = minus_done_reg;
        code            = SEG_BLANK;
        if (at_last)
        begin
            code = (ann_one ? AN1_BIT : 8'h00) | (ann_two ? AN2_BIT : 8'h00);
        end
        else if ((idx_reg == '0) || (mag_reg != '0))
        begin
            code     = seg_code(rem_full[3:0]);
            mag_next = quot;
        end
        else if (neg_reg && !minus_done_reg)
        begin
            code            = SEG_MINUS;
            minus_done_next = 1'b1;
        end
        if (idx_reg == '0)
        begin
            code = code | START_BIT;
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            byte_next      = code;
            last_next      = at_last;
            idx_next       = idx_reg + 1'b1;
            if (at_last)
            begin
                busy_next = 1'b0;
            end
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (item_take)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load a new item, or advance on each emitted byte
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        if (item_take)
        begin
            mag_reg        <= item.mag;
            neg_reg        <= item.neg;
            minus_done_reg <= 1'b0;
        end
        else if (emit)
        begin
            mag_reg        <= mag_next;
            minus_done_reg <= minus_done_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = byte_reg;
    assign frame_last = last_reg;

endmodule

`default_nettype wire

/* hw/rtl/integer_to_seven_segment_frame_core.sv */
// Top level of the seven-segment frame core: configuration registers and datapath.
`default_nettype none

// Takes a signed 16-bit value, saturates it to -999..9999 and sends one display
// frame of five bytes, one byte per cycle while out_stall is low: byte 0 is the
// rightmost digit with the start bit in bit 7, byte 3 the leftmost digit (or
// minus, or blank), and byte 4 carries the two annunciator bits and sets
// frame_last. The digit serializer extracts one decimal digit per byte; a word
// passes the input register and the serializer's output register before its
// first byte appears. The next value waits in the input register and enters the
// serializer as the last byte is loaded into the output register, so frames
// follow with no gap. The annunciator registers are read as that byte is formed.

module integer_to_seven_segment_frame_core
    import i2ssf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] shown_value,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [7:0]              frame_byte,
    output logic                    frame_last,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic               cfg_data
);

    localparam logic CFG_ANN_ONE = 1'b0;
    localparam logic CFG_ANN_TWO = 1'b1;

    logic  ann_one_reg;
    logic  ann_two_reg;
    logic  item_valid;
    item_t item;
    logic  item_take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ann_one_reg <= 1'b0;
            ann_two_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ANN_ONE: ann_one_reg <= cfg_data;
                CFG_ANN_TWO: ann_two_reg <= cfg_data;
                default:     ann_one_reg <= ann_one_reg;
            endcase
        end
    end

    i2ssf_clamp u_clamp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .shown_value (shown_value),
        .item_valid  (item_valid),
        .item        (item),
        .item_take   (item_take)
    );

    i2ssf_digit_ser u_digit_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .ann_one    (ann_one_reg),
        .ann_two    (ann_two_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .frame_last (frame_last)
    );

endmodule

`default_nettype wire
